### rtl/afk_pkg.sv
// ----------------------------------------------------------------------------
// afk_pkg
// Types, constants and tables shared by the forward kinematics pipeline.
// ----------------------------------------------------------------------------
package afk_pkg;

	localparam int ANGLE_BITS = 16;
	localparam int REG_W      = 17;
	localparam int REG_COUNT  = 8;
	localparam int IDX_W      = 3;
	localparam int OUT_W      = 20;
	localparam int POS_W      = 24;
	localparam int SC_W       = 32;
	localparam int CW         = 34;
	localparam int STEPS      = 24;
	localparam int STEP_W     = 5;
	localparam int PROD_W     = SC_W + POS_W;
	localparam int SUM_W      = PROD_W + 2;
	localparam int SC_FRAC    = 30;
	localparam int ROT_LAT    = 2;
	localparam int PIPE_LEN   = STEPS + 4 * ROT_LAT;

	localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);

	typedef enum logic [IDX_W-1:0] {
		REG_BASE_HEIGHT,
		REG_UPPER_LINK,
		REG_FORE_LINK,
		REG_HAND_LINK,
		REG_SHOULDER_SIDE,
		REG_ELBOW_SIDE,
		REG_WRIST_SIDE,
		REG_WRIST_DROP
	} cfg_reg_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic                 flip;
	} cordic_t;

	typedef struct packed {
		logic signed [SC_W-1:0] s;
		logic signed [SC_W-1:0] c;
	} sincos_t;

	function automatic logic signed [CW-1:0] atan_lut(input logic [STEP_W-1:0] step);
		logic signed [CW-1:0] r;
		case (step)
			5'd0:    r = CW'(536870912);
			5'd1:    r = CW'(316933406);
			5'd2:    r = CW'(167458907);
			5'd3:    r = CW'(85004756);
			5'd4:    r = CW'(42667331);
			5'd5:    r = CW'(21354465);
			5'd6:    r = CW'(10679838);
			5'd7:    r = CW'(5340245);
			5'd8:    r = CW'(2670163);
			5'd9:    r = CW'(1335087);
			5'd10:   r = CW'(667544);
			5'd11:   r = CW'(333772);
			5'd12:   r = CW'(166886);
			5'd13:   r = CW'(83443);
			5'd14:   r = CW'(41722);
			5'd15:   r = CW'(20861);
			5'd16:   r = CW'(10430);
			5'd17:   r = CW'(5215);
			5'd18:   r = CW'(2608);
			5'd19:   r = CW'(1304);
			5'd20:   r = CW'(652);
			5'd21:   r = CW'(326);
			5'd22:   r = CW'(163);
			5'd23:   r = CW'(81);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

### rtl/afk_cordic_cell.sv
// ----------------------------------------------------------------------------
// afk_cordic_cell
// One registered rotation-mode CORDIC iteration.
// ----------------------------------------------------------------------------
module afk_cordic_cell import afk_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [STEP_W-1:0] step,
	input  cordic_t           d,
	output cordic_t           q
);

	cordic_t              nxt;
	cordic_t              res_q;
	logic signed [CW-1:0] dx;
	logic signed [CW-1:0] dy;

	always_comb begin
		dx = d.y >>> step;
		dy = d.x >>> step;
		nxt.flip = d.flip;
		if (!d.z[CW-1]) begin
			nxt.x = d.x - dx;
			nxt.y = d.y + dy;
			nxt.z = d.z - atan_lut(step);
		end else begin
			nxt.x = d.x + dx;
			nxt.y = d.y - dy;
			nxt.z = d.z + atan_lut(step);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= nxt;
		end
	end

	assign q = res_q;

endmodule

### rtl/afk_rot_cell.sv
// ----------------------------------------------------------------------------
// afk_rot_cell
// Two-stage plane rotation: products, then rounded sums plus an offset.
// r1 = round(c*a + s*b) + off, r2 = round(c*b - s*a)
// ----------------------------------------------------------------------------
module afk_rot_cell import afk_pkg::*; (
	input  logic                   clk,
	input  logic                   en,
	input  sincos_t                sc,
	input  logic signed [POS_W-1:0] a,
	input  logic signed [POS_W-1:0] b,
	input  logic signed [POS_W-1:0] off,
	output logic signed [POS_W-1:0] r1,
	output logic signed [POS_W-1:0] r2
);

	localparam logic signed [SUM_W-1:0] RND = SUM_W'(1) <<< (SC_FRAC - 1);

	logic signed [PROD_W-1:0] ca_s1, sb_s1, cb_s1, sa_s1;
	logic signed [POS_W-1:0]  off_s1;
	logic signed [SUM_W-1:0]  sum1, sum2;
	logic signed [POS_W-1:0]  r1_s2, r2_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ca_s1  <= PROD_W'(sc.c) * PROD_W'(a);
			sb_s1  <= PROD_W'(sc.s) * PROD_W'(b);
			cb_s1  <= PROD_W'(sc.c) * PROD_W'(b);
			sa_s1  <= PROD_W'(sc.s) * PROD_W'(a);
			off_s1 <= off;
		end
	end

	always_comb begin
		sum1 = SUM_W'(ca_s1) + SUM_W'(sb_s1) + RND;
		sum2 = SUM_W'(cb_s1) - SUM_W'(sa_s1) + RND;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r1_s2 <= POS_W'(sum1 >>> SC_FRAC) + off_s1;
			r2_s2 <= POS_W'(sum2 >>> SC_FRAC);
		end
	end

	assign r1 = r1_s2;
	assign r2 = r2_s2;

endmodule

### rtl/arm_forward_kinematics.sv
// ----------------------------------------------------------------------------
// arm_forward_kinematics
// Tip position of a four-joint serial arm from its joint angles.
// ----------------------------------------------------------------------------
// One joint vector is taken per cycle unless the output stalls, and each gives one
// tip position: 24 CORDIC cells per joint run side by side, then four registered
// rotation cells (wrist, elbow, shoulder, base) and a saturating output register.
// A stalled output holds the whole pipeline. Link registers are read live and
// must only be written while no transaction is in flight.
module arm_forward_kinematics import afk_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    wr_en,
	input  logic [IDX_W-1:0]        wr_index,
	input  logic [REG_W-1:0]        wr_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [ANGLE_BITS-1:0]   angle_base,
	input  logic [ANGLE_BITS-1:0]   angle_shoulder,
	input  logic [ANGLE_BITS-1:0]   angle_elbow,
	input  logic [ANGLE_BITS-1:0]   angle_wrist,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [OUT_W-1:0] tip_x,
	output logic signed [OUT_W-1:0] tip_y,
	output logic signed [OUT_W-1:0] tip_z
);

	localparam logic signed [POS_W-1:0] OUT_MAX = POS_W'((1 << (OUT_W - 1)) - 1);
	localparam logic signed [POS_W-1:0] OUT_MIN = -POS_W'(1 << (OUT_W - 1));

	logic signed [REG_W-1:0] cfg_q [REG_COUNT];
	logic                    adv;
	logic [PIPE_LEN-1:0]     vld_q;
	logic                    out_valid_q;
	logic signed [OUT_W-1:0] tip_x_q, tip_y_q, tip_z_q;

	logic [ANGLE_BITS-1:0]   ang [4];
	cordic_t                 cd [4][STEPS+1];
	sincos_t                 sc [4];

	sincos_t                 el_sc_q [2];
	sincos_t                 sh_sc_q [4];
	sincos_t                 ba_sc_q [6];

	logic signed [POS_W-1:0] w_px, w_pz, e_px, e_pz, s_px, s_pz, b_ty, b_tx;
	logic signed [POS_W-1:0] pz_s1, pz_s2, py_tot, tz;

	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [POS_W-1:0] v);
		if (v > OUT_MAX) begin
			return OUT_MAX[OUT_W-1:0];
		end else if (v < OUT_MIN) begin
			return OUT_MIN[OUT_W-1:0];
		end
		return v[OUT_W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[REG_BASE_HEIGHT]   <= REG_W'(16384);
			cfg_q[REG_UPPER_LINK]    <= REG_W'(13107);
			cfg_q[REG_FORE_LINK]     <= REG_W'(13107);
			cfg_q[REG_HAND_LINK]     <= REG_W'(9830);
			cfg_q[REG_SHOULDER_SIDE] <= -REG_W'(2621);
			cfg_q[REG_ELBOW_SIDE]    <= REG_W'(2621);
			cfg_q[REG_WRIST_SIDE]    <= -REG_W'(2621);
			cfg_q[REG_WRIST_DROP]    <= -REG_W'(2621);
		end else if (wr_en) begin
			cfg_q[wr_index] <= wr_data;
		end
	end

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	assign ang[0] = angle_wrist;
	assign ang[1] = angle_elbow;
	assign ang[2] = angle_shoulder;
	assign ang[3] = angle_base;

	for (genvar j = 0; j < 4; j++) begin : g_joint
		logic [31:0] u;
		logic [31:0] u_q;

		always_comb begin
			u   = {ang[j], (32 - ANGLE_BITS)'(0)};
			u_q = u + 32'h4000_0000;
			cd[j][0].flip = u_q[31];
			cd[j][0].x    = CORDIC_GAIN;
			cd[j][0].y    = '0;
			cd[j][0].z    = CW'($signed(u_q[31] ? (u ^ 32'h8000_0000) : u));
		end

		for (genvar i = 0; i < STEPS; i++) begin : g_step
			afk_cordic_cell u_cell (
				.clk  (clk),
				.en   (adv),
				.step (STEP_W'(i)),
				.d    (cd[j][i]),
				.q    (cd[j][i+1])
			);
		end

		always_comb begin
			sc[j].s = SC_W'(cd[j][STEPS].flip ? -cd[j][STEPS].y : cd[j][STEPS].y);
			sc[j].c = SC_W'(cd[j][STEPS].flip ? -cd[j][STEPS].x : cd[j][STEPS].x);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			el_sc_q[0] <= sc[1];
			el_sc_q[1] <= el_sc_q[0];
			sh_sc_q[0] <= sc[2];
			for (int k = 1; k < 4; k++) begin
				sh_sc_q[k] <= sh_sc_q[k-1];
			end
			ba_sc_q[0] <= sc[3];
			for (int k = 1; k < 6; k++) begin
				ba_sc_q[k] <= ba_sc_q[k-1];
			end
			pz_s1 <= s_pz;
			pz_s2 <= pz_s1;
		end
	end

	afk_rot_cell u_rot_wrist (
		.clk (clk), .en (adv), .sc (sc[0]),
		.a   (POS_W'(cfg_q[REG_HAND_LINK])),
		.b   (POS_W'(cfg_q[REG_WRIST_DROP])),
		.off (POS_W'(cfg_q[REG_FORE_LINK])),
		.r1  (w_px), .r2 (w_pz)
	);

	afk_rot_cell u_rot_elbow (
		.clk (clk), .en (adv), .sc (el_sc_q[1]),
		.a   (w_px), .b (w_pz),
		.off (POS_W'(cfg_q[REG_UPPER_LINK])),
		.r1  (e_px), .r2 (e_pz)
	);

	afk_rot_cell u_rot_shoulder (
		.clk (clk), .en (adv), .sc (sh_sc_q[3]),
		.a   (e_px), .b (e_pz), .off ('0),
		.r1  (s_px), .r2 (s_pz)
	);

	assign py_tot = POS_W'(cfg_q[REG_WRIST_SIDE]) + POS_W'(cfg_q[REG_ELBOW_SIDE])
		+ POS_W'(cfg_q[REG_SHOULDER_SIDE]);

	afk_rot_cell u_rot_base (
		.clk (clk), .en (adv), .sc (ba_sc_q[5]),
		.a   (py_tot), .b (s_px), .off ('0),
		.r1  (b_ty), .r2 (b_tx)
	);

	assign tz = pz_s2 + POS_W'(cfg_q[REG_BASE_HEIGHT]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_q       <= {vld_q[PIPE_LEN-2:0], in_valid};
			out_valid_q <= vld_q[PIPE_LEN-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tip_x_q <= sat_out(b_tx);
			tip_y_q <= sat_out(b_ty);
			tip_z_q <= sat_out(tz);
		end
	end

	assign out_valid = out_valid_q;
	assign tip_x     = tip_x_q;
	assign tip_y     = tip_y_q;
	assign tip_z     = tip_z_q;

`ifndef NO_ASSERTIONS
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_q[0])
		else $error("accepted transaction did not enter the pipeline");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> $stable(vld_q))
		else $error("pipeline moved while stalled");

	a_out_from_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(vld_q[PIPE_LEN-1]))
		else $error("output valid without a transaction at the pipeline end");
`endif

endmodule
